// File: sv/i2cte_pkg.sv
package i2cte_pkg;

   // Bus phase codes.
   localparam logic [2:0] PH_STOPPED = 3'd0;
   localparam logic [2:0] PH_ADDR    = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_ACKRX   = 3'd3;
   localparam logic [2:0] PH_TXDATA  = 3'd4;
   localparam logic [2:0] PH_NACK    = 3'd5;
   localparam logic [2:0] PH_ACKRECV = 3'd6;
   localparam logic [2:0] PH_ACKTX   = 3'd7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 1;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       bit_pending;
      logic       drive_release;
      logic [2:0] phase;
      logic [7:0] shift_byte;
      logic [2:0] bit_count;
   } state_type;

   typedef struct packed {
      logic       sda_in;
      logic       scl_in;
      logic       addr_ack;
      logic       data_ack;
      logic       tx_ready;
      logic [7:0] tx_byte;
      logic       tx_more;
   } item_type;

   typedef struct packed {
      logic       sda_read;
      logic       start_event;
      logic       stop_event;
      logic       rx_strobe;
      logic       rx_is_address;
      logic [7:0] rx_byte;
      logic       tx_fetch;
      logic       tx_end;
      logic [2:0] bus_phase;
   } result_type;

   localparam state_type STATE_RESET = '{
      scl_level:     1'b1,
      sda_level:     1'b1,
      bit_pending:   1'b0,
      drive_release: 1'b1,
      phase:         PH_STOPPED,
      shift_byte:    8'd0,
      bit_count:     3'd0
   };

endpackage

// File: sv/i2cte_step.sv
module i2cte_step
   import i2cte_pkg::*;
(
   input  state_type  state,
   input  item_type   item,
   output state_type  state_next,
   output result_type result
);

   always_comb begin
      state_type  s;
      logic [2:0] nx;
      logic       want;
      logic       strobe;
      logic       is_addr;
      logic [7:0] rxb;
      logic       fetch;
      logic       tend;
      logic       ev_start;
      logic       ev_stop;

      s        = state;
      nx       = PH_STOPPED;
      want     = 1'b0;
      strobe   = 1'b0;
      is_addr  = 1'b0;
      rxb      = 8'd0;
      fetch    = 1'b0;
      tend     = 1'b0;
      ev_start = 1'b0;
      ev_stop  = 1'b0;

      if (state.scl_level == item.scl_in) begin
         // SCL steady high with SDA moving is a bus condition.
         if (state.scl_level && (state.sda_level != item.sda_in)) begin
            if (item.sda_in) begin
               ev_stop = 1'b1;
               s.phase = PH_STOPPED;
            end else begin
               s.shift_byte    = 8'd0;
               s.bit_count     = 3'd0;
               s.drive_release = 1'b1;
               ev_start        = 1'b1;
               s.phase         = PH_ADDR;
            end
            s.bit_pending = 1'b0;
         end
      end else if (!item.scl_in) begin
         // Falling SCL: release the line and act on the latched bit.
         s.drive_release = 1'b1;
         if (state.bit_pending) begin
            unique case (state.phase)
               PH_ADDR, PH_DATA: begin
                  nx           = state.phase;
                  s.shift_byte = {state.shift_byte[6:0], state.sda_level};
                  s.bit_count  = state.bit_count + 3'd1;
                  if (state.bit_count == 3'd7) begin
                     strobe  = 1'b1;
                     is_addr = (state.phase == PH_ADDR);
                     rxb     = s.shift_byte;
                     if ((state.phase == PH_ADDR) ? item.addr_ack : item.data_ack) begin
                        s.drive_release = 1'b0;
                        if ((state.phase == PH_ADDR) && s.shift_byte[0]) begin
                           nx = PH_ACKTX;
                        end else begin
                           nx = PH_ACKRECV;
                        end
                     end else begin
                        nx = PH_NACK;
                     end
                  end
               end
               PH_ACKRX: begin
                  want = !state.sda_level;
               end
               PH_TXDATA: begin
                  nx              = PH_TXDATA;
                  s.drive_release = state.shift_byte[7];
                  s.shift_byte    = {state.shift_byte[6:0], 1'b0};
                  s.bit_count     = state.bit_count + 3'd1;
                  if (state.bit_count == 3'd7) begin
                     tend = 1'b1;
                     nx   = item.tx_more ? PH_ACKRX : PH_STOPPED;
                  end
               end
               PH_ACKRECV: begin
                  nx = PH_DATA;
               end
               PH_ACKTX: begin
                  want = 1'b1;
               end
               default: begin
                  nx = PH_STOPPED;
               end
            endcase
            if (want) begin
               fetch = 1'b1;
               if (item.tx_ready) begin
                  // Load the byte and drive its first bit straight away.
                  s.drive_release = item.tx_byte[7];
                  s.shift_byte    = {item.tx_byte[6:0], 1'b0};
                  s.bit_count     = 3'd1;
                  nx              = PH_TXDATA;
               end else begin
                  nx = PH_STOPPED;
               end
            end
            if (nx == PH_STOPPED) begin
               ev_stop = 1'b1;
            end
            s.phase = nx;
         end
         s.bit_pending = 1'b1;
      end

      s.scl_level = item.scl_in;
      s.sda_level = item.sda_in;

      state_next           = s;
      result.sda_read      = s.sda_level & s.drive_release;
      result.start_event   = ev_start;
      result.stop_event    = ev_stop;
      result.rx_strobe     = strobe;
      result.rx_is_address = is_addr;
      result.rx_byte       = rxb;
      result.tx_fetch      = fetch;
      result.tx_end        = tend;
      result.bus_phase     = s.phase;
   end

endmodule

// File: sv/i2c_target_bit_engine.sv
// A request item is captured in the input register when it is accepted; the step logic is
// combinational, and its result is captured in the response register when that register is
// free or being read. Throughput: one item per cycle when the response side does not stall;
// the only loop is the bus state register around the step logic.
// Reset: synchronous, active high; the bus state returns to SCL and SDA high, line released,
// phase stopped, nothing pending, and both pipeline registers are emptied.
module i2c_target_bit_engine
   import i2cte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // From bit 0: sda_in, scl_in, addr_ack, data_ack, tx_ready, tx_byte[7:0], tx_more,
   // then two zero bits.
   input  logic [REQ_DATA_W-1:0] req_tdata,

   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0: sda_read, start_event, stop_event, rx_strobe, rx_byte[7:0], tx_fetch,
   // tx_end, bus_phase[2:0], then seven zero bits.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Bit 0: rx_is_address.
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // Pipeline registers.
   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;

   // Bus state carried from one item to the next.
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;

   logic       advance;
   logic       req_accept;

   // The response register empties when taken, so the input register moves on
   // whenever the response register is free or being read in this cycle.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   i2cte_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.sda_in   <= req_tdata[0];
         in_item_ff.scl_in   <= req_tdata[1];
         in_item_ff.addr_ack <= req_tdata[2];
         in_item_ff.data_ack <= req_tdata[3];
         in_item_ff.tx_ready <= req_tdata[4];
         in_item_ff.tx_byte  <= req_tdata[12:5];
         in_item_ff.tx_more  <= req_tdata[13];
      end
   end

   // The state only moves when an item passes from the input register to the
   // response register, so each item is applied exactly once.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.bus_phase, out_ff.tx_end, out_ff.tx_fetch,
                        out_ff.rx_byte, out_ff.rx_strobe, out_ff.stop_event,
                        out_ff.start_event, out_ff.sda_read};
   assign rsp_tuser  = out_ff.rx_is_address;

   // A start condition always leaves the machine in the address phase.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.start_event) |-> (out_ff.bus_phase == PH_ADDR))
      else $error("start event without address phase");

   // The address flag is only ever raised with a received byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.rx_is_address) |-> out_ff.rx_strobe)
      else $error("address flag without receive strobe");

   // Receiving a byte and fetching a byte to send never happen on the same edge.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.rx_strobe && out_ff.tx_fetch))
      else $error("receive strobe and transmit fetch together");

   // A held item in the input register is not lost while the response side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("stalled input item dropped or changed");

endmodule

// File: dv/testbench.sv
module testbench;
   import i2cte_pkg::*;

   // Simulation bounds.
   localparam int RANDOM_WRITES = 750;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int DIRECTED_ROWS = 25;

   // One line write as it is queued for the sender. Where known is set, the
   // result was worked out by hand and stands in place of the predicted one.
   typedef struct packed {
      item_type   wr;
      logic       known;
      result_type want;
   } line_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   i2c_target_bit_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // The target as the testbench sees it: its bus state, the line writes still
   // to be sent, and the results that are owed by the block, oldest first.
   state_type      tgt = STATE_RESET;
   line_write_type line_writes [$];
   result_type     awaited_views [$];
   line_write_type directed_rows [DIRECTED_ROWS];
   int             fault_count = 0;
   int             cycle_count = 0;
   logic [7:0]     stall_mask = 8'hFF;

   // Levels last written by the stimulus generator, and a budget of bit clocks
   // that lets a transfer be cut short on purpose.
   logic          cur_sda = 1'b1;
   logic          cur_scl = 1'b1;
   int            clocks_left;

   // ------------------------------------------------------------------------
   // Prediction.
   // ------------------------------------------------------------------------

   // Shifts the stored SDA level into the receive byte; true once eight bits are in.
   function automatic bit shift_in_bit();
      logic [3:0] n;
      n = {1'b0, tgt.bit_count} + 4'd1;
      tgt.shift_byte = {tgt.shift_byte[6:0], tgt.sda_level};
      if (n == 4'd8) begin
         tgt.bit_count = 3'd0;
         return 1'b1;
      end
      tgt.bit_count = n[2:0];
      return 1'b0;
   endfunction

   // Puts the most significant bit of the transmit byte on the line (a zero pulls
   // SDA low) and shifts left; true once the eighth bit has gone out.
   function automatic bit shift_out_bit();
      logic [3:0] n;
      n = {1'b0, tgt.bit_count} + 4'd1;
      tgt.drive_release = tgt.shift_byte[7];
      tgt.shift_byte = {tgt.shift_byte[6:0], 1'b0};
      if (n == 4'd8) begin
         tgt.bit_count = 3'd0;
         return 1'b1;
      end
      tgt.bit_count = n[2:0];
      return 1'b0;
   endfunction

   // Applies one line write to the target state and returns what the block should report.
   function automatic result_type advance_target(input item_type wr);
      result_type r;
      logic [2:0] nxt;
      logic       fetch_wanted;
      r = '0;
      if (tgt.scl_level == wr.scl_in) begin
         // SCL steady: only an SDA edge while SCL is high means anything.
         if (tgt.scl_level && tgt.sda_level != wr.sda_in) begin
            if (wr.sda_in) begin
               r.stop_event = 1'b1;
               tgt.phase = PH_STOPPED;
            end else begin
               tgt.shift_byte = 8'd0;
               tgt.bit_count = 3'd0;
               tgt.drive_release = 1'b1;
               r.start_event = 1'b1;
               tgt.phase = PH_ADDR;
            end
            tgt.bit_pending = 1'b0;
         end
      end else if (!wr.scl_in) begin
         // Falling SCL: let go of the line, then act on the bit of the last high period.
         tgt.drive_release = 1'b1;
         if (tgt.bit_pending) begin
            nxt = PH_STOPPED;
            fetch_wanted = 1'b0;
            case (tgt.phase)
               PH_ADDR: begin
                  nxt = PH_ADDR;
                  if (shift_in_bit()) begin
                     r.rx_strobe = 1'b1;
                     r.rx_is_address = 1'b1;
                     r.rx_byte = tgt.shift_byte;
                     if (wr.addr_ack) begin
                        tgt.drive_release = 1'b0;
                        nxt = tgt.shift_byte[0] ? PH_ACKTX : PH_ACKRECV;
                     end else begin
                        nxt = PH_NACK;
                     end
                  end
               end
               PH_DATA: begin
                  nxt = PH_DATA;
                  if (shift_in_bit()) begin
                     r.rx_strobe = 1'b1;
                     r.rx_byte = tgt.shift_byte;
                     if (wr.data_ack) begin
                        tgt.drive_release = 1'b0;
                        nxt = PH_ACKRECV;
                     end else begin
                        nxt = PH_NACK;
                     end
                  end
               end
               PH_ACKRX: begin
                  // The controller acknowledges by holding SDA low.
                  fetch_wanted = !tgt.sda_level;
               end
               PH_TXDATA: begin
                  nxt = PH_TXDATA;
                  if (shift_out_bit()) begin
                     r.tx_end = 1'b1;
                     nxt = wr.tx_more ? PH_ACKRX : PH_STOPPED;
                  end
               end
               PH_ACKRECV: begin
                  nxt = PH_DATA;
               end
               PH_ACKTX: begin
                  fetch_wanted = 1'b1;
               end
               default: begin
                  nxt = PH_STOPPED;
               end
            endcase
            if (fetch_wanted) begin
               r.tx_fetch = 1'b1;
               if (wr.tx_ready) begin
                  tgt.shift_byte = wr.tx_byte;
                  tgt.bit_count = 3'd0;
                  void'(shift_out_bit());
                  nxt = PH_TXDATA;
               end else begin
                  nxt = PH_STOPPED;
               end
            end
            if (nxt == PH_STOPPED) begin
               r.stop_event = 1'b1;
            end
            tgt.phase = nxt;
         end
         tgt.bit_pending = 1'b1;
      end
      tgt.scl_level = wr.scl_in;
      tgt.sda_level = wr.sda_in;
      r.sda_read = tgt.sda_level & tgt.drive_release;
      r.bus_phase = tgt.phase;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Packing of the stream words.
   // ------------------------------------------------------------------------

   function automatic logic [REQ_DATA_W-1:0] encode_write(input item_type wr);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0]    = wr.sda_in;
      d[1]    = wr.scl_in;
      d[2]    = wr.addr_ack;
      d[3]    = wr.data_ack;
      d[4]    = wr.tx_ready;
      d[12:5] = wr.tx_byte;
      d[13]   = wr.tx_more;
      return d;
   endfunction

   function automatic result_type decode_view(input logic [RSP_DATA_W-1:0] d,
                                              input logic [RSP_USER_W-1:0] u);
      result_type r;
      r.sda_read      = d[0];
      r.start_event   = d[1];
      r.stop_event    = d[2];
      r.rx_strobe     = d[3];
      r.rx_byte       = d[11:4];
      r.tx_fetch      = d[12];
      r.tx_end        = d[13];
      r.bus_phase     = d[16:14];
      r.rx_is_address = u[0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------

   // A line write for the directed table; side sets every back-end flag at once.
   function automatic item_type make_write(input logic sda, input logic scl,
                                           input logic side, input logic [7:0] tbyte);
      item_type wr;
      wr.sda_in   = sda;
      wr.scl_in   = scl;
      wr.addr_ack = side;
      wr.data_ack = side;
      wr.tx_ready = side;
      wr.tx_byte  = tbyte;
      wr.tx_more  = side;
      return wr;
   endfunction

   // A hand-worked result in which no byte moves.
   function automatic result_type make_view(input logic sda_read, input logic start_ev,
                                            input logic stop_ev, input logic [2:0] ph);
      result_type r;
      r = '0;
      r.sda_read    = sda_read;
      r.start_event = start_ev;
      r.stop_event  = stop_ev;
      r.bus_phase   = ph;
      return r;
   endfunction

   // Queues one write of the two line levels; the back-end answers are random but
   // lean towards the answers that keep a transfer going.
   task automatic put_levels(input logic sda, input logic scl);
      line_write_type e;
      e.wr.sda_in   = sda;
      e.wr.scl_in   = scl;
      e.wr.addr_ack = ($urandom_range(0, 5) != 0);
      e.wr.data_ack = ($urandom_range(0, 5) != 0);
      e.wr.tx_ready = ($urandom_range(0, 7) != 0);
      e.wr.tx_byte  = 8'($urandom_range(0, 255));
      e.wr.tx_more  = ($urandom_range(0, 5) != 0);
      e.known       = 1'b0;
      e.want        = '0;
      line_writes.push_back(e);
      cur_sda = sda;
      cur_scl = scl;
   endtask

   // One SCL pulse with SDA set up while SCL is low; the target samples the bit
   // on the falling edge that ends the pulse.
   task automatic clock_bit(input logic b);
      if (clocks_left > 0) begin
         clocks_left--;
         put_levels(b, 1'b0);
         put_levels(b, 1'b1);
         put_levels(b, 1'b0);
      end
   endtask

   // A controller transfer: START (or repeated START), address byte, then a few
   // bytes written or read, and usually a STOP. Some transfers are cut short.
   task automatic gen_transfer();
      logic [7:0] addr_byte;
      int         nbytes;
      bit         last;
      addr_byte = 8'($urandom_range(0, 255));
      nbytes = $urandom_range(0, 3);
      clocks_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : 1000;

      // Bring both lines high, then pull SDA low with SCL high.
      if (!(cur_scl && cur_sda)) begin
         if (cur_scl) begin
            put_levels(cur_sda, 1'b0);
         end
         put_levels(1'b1, 1'b0);
         put_levels(1'b1, 1'b1);
      end
      put_levels(1'b0, 1'b1);
      put_levels(1'b0, 1'b0);

      for (int i = 7; i >= 0; i--) begin
         clock_bit(addr_byte[i]);
      end
      // Acknowledge clock of the address byte: the controller leaves SDA released.
      clock_bit(1'b1);

      for (int k = 0; k < nbytes; k++) begin
         last = (k == nbytes - 1);
         if (addr_byte[0]) begin
            // Read: the data clocks with SDA released, then the controller's answer,
            // mostly an acknowledge except on the final byte.
            repeat (7) clock_bit(1'b1);
            if (last) begin
               clock_bit($urandom_range(0, 3) != 0);
            end else begin
               clock_bit($urandom_range(0, 6) == 0);
            end
         end else begin
            for (int i = 0; i < 8; i++) begin
               clock_bit(1'($urandom_range(0, 1)));
            end
            clock_bit(1'b1);
         end
      end

      // Usually a STOP; otherwise the next transfer opens with a repeated START.
      if ($urandom_range(0, 4) != 0) begin
         if (cur_scl) begin
            put_levels(cur_sda, 1'b0);
         end
         put_levels(1'b0, 1'b0);
         put_levels(1'b0, 1'b1);
         put_levels(1'b1, 1'b1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: stall pattern, timeout and checking.
   // ------------------------------------------------------------------------

   // The receiver follows a ready pattern that is stepped through and redrawn
   // by the cycle counter; an all-ready pattern is drawn often so that long
   // stretches pass with no stalls at all.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            stall_mask <= 8'hFF;
         end else begin
            stall_mask <= 8'($urandom_range(1, 255));
         end
      end
      rsp_tready <= stall_mask[cycle_count % 8];
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   // Every accepted result is held against the oldest outstanding expectation.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = decode_view(rsp_tdata, rsp_tuser);
         if (awaited_views.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got 0x%0h",
                     $time, got);
            fault_count++;
         end else begin
            want = awaited_views.pop_front();
            compare_field("sda_read", 8'(want.sda_read), 8'(got.sda_read));
            compare_field("start_event", 8'(want.start_event), 8'(got.start_event));
            compare_field("stop_event", 8'(want.stop_event), 8'(got.stop_event));
            compare_field("rx_strobe", 8'(want.rx_strobe), 8'(got.rx_strobe));
            compare_field("rx_is_address", 8'(want.rx_is_address),
                          8'(got.rx_is_address));
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("tx_fetch", 8'(want.tx_fetch), 8'(got.tx_fetch));
            compare_field("tx_end", 8'(want.tx_end), 8'(got.tx_end));
            compare_field("bus_phase", 8'(want.bus_phase), 8'(got.bus_phase));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side: directed table, random transfers, bursty sender.
   // ------------------------------------------------------------------------

   initial begin
      int burst_left;
      int gap;
      line_write_type e;
      result_type     pred;

      // The directed table walks the bus conditions from reset: an idle write,
      // START, STOP, a falling SCL while stopped with no bit pending, SDA moving
      // with SCL low, a rising SCL, a falling SCL with a bit pending (which raises
      // stop again), a rising SCL, then START, four address bits and a STOP in the
      // address. The back-end flags swing between all zeros and all ones.
      directed_rows = '{
         '{make_write(1'b1, 1'b1, 1'b0, 8'h00), 1'b1, make_view(1'b1, 1'b0, 1'b0, PH_STOPPED)},
         '{make_write(1'b0, 1'b1, 1'b1, 8'hFF), 1'b1, make_view(1'b0, 1'b1, 1'b0, PH_ADDR)},
         '{make_write(1'b1, 1'b1, 1'b0, 8'h00), 1'b1, make_view(1'b1, 1'b0, 1'b1, PH_STOPPED)},
         '{make_write(1'b1, 1'b0, 1'b1, 8'hFF), 1'b1, make_view(1'b1, 1'b0, 1'b0, PH_STOPPED)},
         '{make_write(1'b0, 1'b0, 1'b0, 8'h00), 1'b1, make_view(1'b0, 1'b0, 1'b0, PH_STOPPED)},
         '{make_write(1'b0, 1'b1, 1'b1, 8'hFF), 1'b1, make_view(1'b0, 1'b0, 1'b0, PH_STOPPED)},
         '{make_write(1'b1, 1'b0, 1'b0, 8'h5A), 1'b1, make_view(1'b1, 1'b0, 1'b1, PH_STOPPED)},
         '{make_write(1'b1, 1'b1, 1'b1, 8'hA5), 1'b1, make_view(1'b1, 1'b0, 1'b0, PH_STOPPED)},
         '{make_write(1'b0, 1'b1, 1'b0, 8'h00), 1'b1, make_view(1'b0, 1'b1, 1'b0, PH_ADDR)},
         '{make_write(1'b0, 1'b0, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0},
         '{make_write(1'b1, 1'b1, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b1, 1'b0, 1'b0, 8'h01), 1'b0, '0},
         '{make_write(1'b0, 1'b0, 1'b1, 8'h80), 1'b0, '0},
         '{make_write(1'b0, 1'b1, 1'b0, 8'h7F), 1'b0, '0},
         '{make_write(1'b0, 1'b0, 1'b1, 8'hFE), 1'b0, '0},
         '{make_write(1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0},
         '{make_write(1'b1, 1'b1, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0},
         '{make_write(1'b0, 1'b0, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b0, 1'b1, 1'b0, 8'h00), 1'b0, '0},
         '{make_write(1'b0, 1'b0, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
         '{make_write(1'b0, 1'b1, 1'b1, 8'hFF), 1'b0, '0},
         '{make_write(1'b1, 1'b1, 1'b0, 8'h00), 1'b1, make_view(1'b1, 1'b0, 1'b1, PH_STOPPED)}
      };
      foreach (directed_rows[i]) begin
         line_writes.push_back(directed_rows[i]);
      end

      // Random part: mostly well-formed transfers with random content, the rest
      // short runs of arbitrary line levels.
      while (line_writes.size() < DIRECTED_ROWS + RANDOM_WRITES) begin
         if ($urandom_range(0, 9) < 7) begin
            gen_transfer();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               put_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end

      while (reset) @(posedge clock);

      // The sender works in bursts and may drop valid between them. A zero-length
      // gap keeps valid high into the next burst.
      burst_left = 0;
      while (line_writes.size() > 0) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         end
         e = line_writes.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= encode_write(e.wr);
         do @(posedge clock); while (!req_tready);
         // Accepted at this edge: advance the predictor and record the result owed.
         pred = advance_target(e.wr);
         awaited_views.push_back(e.known ? e.want : pred);
         burst_left--;
      end
      req_tvalid <= 1'b0;

      while (awaited_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
